// ===== design/stdec_pkg.sv =====
// shared types and constants for the shape token rle decoder
// used by every module of the block, depends on nothing

package stdec_pkg;

   localparam int unsigned QUEUE_DEPTH_DEF = 4;
   localparam int unsigned REG_W           = 17;
   localparam int unsigned COL_W           = 18;
   localparam logic [COL_W-1:0] COL_MAX    = {COL_W{1'b1}};

   localparam logic CSR_SHAPE_WIDTH  = 1'b0;
   localparam logic CSR_SHAPE_HEIGHT = 1'b1;

   localparam logic [1:0] KIND_SPAN     = 2'd0;
   localparam logic [1:0] KIND_ROW_END  = 2'd1;
   localparam logic [1:0] KIND_LAST_ROW = 2'd2;

   typedef enum logic [1:0] {
      OP_NONE    = 2'd0,
      OP_ROW_END = 2'd1,
      OP_SKIP    = 2'd2,
      OP_SPAN    = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      PH_TOKEN   = 4'b0001,
      PH_SKIP    = 4'b0010,
      PH_RUNPIX  = 4'b0100,
      PH_LITERAL = 4'b1000
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] row;
      logic [15:0] column;
      logic [6:0]  span_length;
      logic [7:0]  pixel;
   } rsp_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] amount;
      logic [7:0] pixel;
      logic       first;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

endpackage

// ===== design/stdec_front.sv =====
// front end: accepts stream bytes, tracks token phase and emits commands
// depends on stdec_pkg

module stdec_front
   import stdec_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  req_type req,
   input  logic    accept,
   output logic    cmd_push,
   output cmd_type cmd
);

   phase_type  phase_ff, phase_in;
   logic [6:0] pending_ff, pending_in;
   phase_type  phase_cur;
   logic [6:0] pending_cur;
   logic [6:0] pending_dec;

   always_comb begin
      phase_cur   = req.first_byte ? PH_TOKEN : phase_ff;
      pending_cur = req.first_byte ? 7'd0 : pending_ff;
      pending_dec = pending_cur - 7'd1;
      phase_in    = phase_cur;
      pending_in  = pending_cur;
      cmd.op      = OP_NONE;
      cmd.amount  = req.data_byte;
      cmd.pixel   = req.data_byte;
      cmd.first   = req.first_byte;
      case (phase_cur)
         PH_SKIP: begin
            cmd.op   = OP_SKIP;
            phase_in = PH_TOKEN;
         end
         PH_RUNPIX: begin
            cmd.op     = OP_SPAN;
            cmd.amount = {1'b0, pending_cur};
            phase_in   = PH_TOKEN;
         end
         PH_LITERAL: begin
            cmd.op     = OP_SPAN;
            cmd.amount = 8'd1;
            pending_in = pending_dec;
            if (pending_dec == 7'd0) begin
               phase_in = PH_TOKEN;
            end
         end
         default: begin
            phase_in = PH_TOKEN;
            if (req.data_byte == 8'd0) begin
               cmd.op = OP_ROW_END;
            end else if (req.data_byte == 8'd1) begin
               phase_in = PH_SKIP;
            end else begin
               pending_in = req.data_byte[7:1];
               phase_in   = req.data_byte[0] ? PH_LITERAL : PH_RUNPIX;
            end
         end
      endcase
   end

   assign cmd_push = accept && req_valid && (cmd.op != OP_NONE || req.first_byte);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_TOKEN;
         pending_ff <= 7'd0;
      end else if (accept && req_valid) begin
         phase_ff   <= phase_in;
         pending_ff <= pending_in;
      end
   end

endmodule

// ===== design/stdec_queue.sv =====
// short command queue between the front and back ends
// depends on stdec_pkg

module stdec_queue
   import stdec_pkg::*;
#(
   parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
)
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  cmd_type        push_cmd,
   input  logic           pop,
   output cmd_type        head_cmd,
   output queue_stat_type stat
);

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

   cmd_type       mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign stat.full  = (count_ff == CW'(DEPTH));
   assign stat.empty = (count_ff == '0);
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign head_cmd   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== design/stdec_back.sv =====
// back end: runs commands on the row and column cursor, clips spans
// and holds the result register; depends on stdec_pkg

module stdec_back
   import stdec_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [REG_W-1:0] shape_width,
   input  logic [REG_W-1:0] shape_height,
   input  logic             cmd_valid,
   input  cmd_type          cmd,
   output logic             cmd_pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp
);

   logic [COL_W-1:0] col_ff, col_in;
   logic [REG_W-1:0] row_ff, row_in;
   logic             done_ff, done_in;
   logic             out_valid_ff, out_valid_in;
   rsp_type          out_ff, out_in;

   logic [COL_W-1:0] col_cur;
   logic [REG_W-1:0] row_cur;
   logic             done_cur;
   logic [COL_W:0]   col_sum;
   logic [COL_W-1:0] col_sat;
   logic [COL_W-1:0] room;
   logic [REG_W:0]   row_next;
   logic             produce;

   assign cmd_pop = cmd_valid && (!out_valid_ff || !rsp_stall);

   always_comb begin
      col_cur  = cmd.first ? '0 : col_ff;
      row_cur  = cmd.first ? '0 : row_ff;
      done_cur = cmd.first ? 1'b0 : done_ff;
      col_sum  = {1'b0, col_cur} + (COL_W + 1)'(cmd.amount);
      col_sat  = col_sum[COL_W] ? COL_MAX : col_sum[COL_W-1:0];
      room     = {1'b0, shape_width} - col_cur;
      row_next = {1'b0, row_cur} + (REG_W + 1)'(1);
      col_in   = col_cur;
      row_in   = row_cur;
      done_in  = done_cur;
      produce  = 1'b0;
      out_in.kind        = KIND_SPAN;
      out_in.row         = row_cur[15:0];
      out_in.column      = col_cur[15:0];
      out_in.span_length = cmd.amount[6:0];
      out_in.pixel       = cmd.pixel;
      if (!done_cur) begin
         case (cmd.op)
            OP_SKIP: begin
               col_in = col_sat;
            end
            OP_SPAN: begin
               col_in = col_sat;
               if (col_cur < {1'b0, shape_width}) begin
                  produce = 1'b1;
                  if ({10'd0, cmd.amount} > room) begin
                     out_in.span_length = room[6:0];
                  end
               end
            end
            OP_ROW_END: begin
               produce            = 1'b1;
               col_in             = '0;
               out_in.column      = '0;
               out_in.span_length = '0;
               out_in.pixel       = '0;
               if (row_next >= {1'b0, shape_height}) begin
                  out_in.kind = KIND_LAST_ROW;
                  done_in     = 1'b1;
               end else begin
                  out_in.kind = KIND_ROW_END;
                  row_in      = row_next[REG_W-1:0];
               end
            end
            default: begin
            end
         endcase
      end
      out_valid_in = cmd_pop ? produce : (out_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         done_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (cmd_pop) begin
            col_ff  <= col_in;
            row_ff  <= row_in;
            done_ff <= done_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop && produce) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp       = out_ff;

endmodule

// ===== design/shape_token_rle_decoder_unit.sv =====
// path: a result passes through the command queue and then the result register
// throughput: one byte per cycle while nothing stalls, set by the cursor update in the back end
// a full command queue stalls the input; a held result stops the back end and so fills the queue
// reset: synchronous, clears phase, cursor, done flag, queue and result valid;
// shape_width and shape_height return to 1
// top level: config registers, front end, command queue and back end; depends on stdec_pkg

module shape_token_rle_decoder_unit
   import stdec_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [REG_W-1:0] csr_wdata
);

   logic [REG_W-1:0] shape_width_ff, shape_height_ff;
   logic             cmd_push, cmd_pop;
   cmd_type          front_cmd, head_cmd;
   queue_stat_type   q_stat;

   always_ff @(posedge clock) begin
      if (reset) begin
         shape_width_ff  <= REG_W'(1);
         shape_height_ff <= REG_W'(1);
      end else if (csr_we) begin
         case (csr_index)
            CSR_SHAPE_WIDTH:  shape_width_ff  <= csr_wdata;
            CSR_SHAPE_HEIGHT: shape_height_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign req_stall = q_stat.full;

   stdec_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req       (req),
      .accept    (!q_stat.full),
      .cmd_push  (cmd_push),
      .cmd       (front_cmd)
   );

   stdec_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_cmd (front_cmd),
      .pop      (cmd_pop),
      .head_cmd (head_cmd),
      .stat     (q_stat)
   );

   stdec_back u_back (
      .clock        (clock),
      .reset        (reset),
      .shape_width  (shape_width_ff),
      .shape_height (shape_height_ff),
      .cmd_valid    (!q_stat.empty),
      .cmd          (head_cmd),
      .cmd_pop      (cmd_pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp          (rsp)
   );

`ifndef SYNTHESIS
   a_span_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.kind == KIND_SPAN |-> rsp.span_length != 7'd0)
      else $error("span with zero length");

   a_row_event_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.kind != KIND_SPAN |->
         rsp.column == 16'd0 && rsp.span_length == 7'd0 && rsp.pixel == 8'd0)
      else $error("row event carries span fields");

   a_queue_stat: assert property (@(posedge clock) disable iff (reset)
      !(q_stat.full && q_stat.empty))
      else $error("queue both full and empty");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !q_stat.full)
      else $error("output valid or queue full after reset");
`endif

endmodule
